// ===== rtl/ibhq_pkg.sv =====
// ibhq_pkg: shared widths, codes, payload and control types for the indexed heap queue
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
package ibhq_pkg;

    localparam int MAX_ELEMENTS = 4096;
    localparam int ID_W         = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = ID_W + 1;
    localparam int SLOT_W       = CNT_W;
    localparam int HS_DEPTH     = MAX_ELEMENTS + 1;
    localparam int KEY_W        = 32;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP   = 1'd1;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DONE  = 2'd3
    } t_status;

    localparam logic [1:0] MARK_ABSENT = 2'd0;
    localparam logic [1:0] MARK_QUEUED = 2'd1;
    localparam logic [1:0] MARK_DONE   = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [ID_W-1:0]         element_id;
        logic signed [KEY_W-1:0] key_value;
    } t_in_word;

    typedef struct packed {
        t_status                 status;
        logic [ID_W-1:0]         out_element;
        logic signed [KEY_W-1:0] out_key;
        logic [CNT_W-1:0]        queued_count;
        logic                    is_empty;
        logic                    is_full;
    } t_out_word;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_LOOK,
        CMD_CODE,
        CMD_UPD_SET,
        CMD_INS,
        CMD_DEL_SET,
        CMD_UP_RD,
        CMD_UP_PAR,
        CMD_UP_MOVE,
        CMD_PLACE,
        CMD_TOP_RD,
        CMD_TOP_GOT,
        CMD_EMPTY,
        CMD_TOP_LAST,
        CMD_DN_KEY,
        CMD_DN_L,
        CMD_DN_LID,
        CMD_DN_LK,
        CMD_DN_RID,
        CMD_DN_RK,
        CMD_DN_MOVE,
        CMD_FIN_DONE,
        CMD_FIN_KEY,
        CMD_FIN_DEL,
        CMD_CLR,
        CMD_SEND
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        t_op        op;
        logic [1:0] mark;
        logic       id_ok;
        logic       count_zero;
        logic       count_one;
        logic       count_full;
        logic       slot_root;
        logic       left_out;
        logic       right_in;
        logic       up_beats;
        logic       dn_go;
        logic       sweep_last;
        logic       out_free;
    } t_dp_stat;

    function automatic logic beats(input logic pol, input logic signed [KEY_W-1:0] a,
                                   input logic signed [KEY_W-1:0] b);
        beats = pol ? (a > b) : (a < b);
    endfunction

endpackage

// ===== rtl/ibhq_ctrl.sv =====
// ibhq_ctrl: sequencer for the heap queue, one micro command per cycle
// depends on ibhq_pkg; drives ibhq_dp through t_dp_cmd and reads t_dp_stat
`timescale 1ns / 1ps
module ibhq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ibhq_pkg::t_dp_stat i_stat,
    output ibhq_pkg::t_dp_cmd  o_cmd
);
    import ibhq_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_LOOK, S_DECIDE, S_UP_RD, S_UP_PAR, S_UP_CMP, S_UP_END,
        S_TOP_RD, S_TOP_GOT, S_TOP_LAST, S_DN_KEY, S_DN_L, S_DN_LID, S_DN_LK,
        S_DN_RID, S_DN_RK, S_DN_CMP, S_DN_END, S_FIN, S_FIN_KEY, S_SEND
    } t_state;

    t_state r_state, n_state;
    logic   r_reply, n_reply;

    always_comb begin
        n_state    = r_state;
        n_reply    = r_reply;
        o_cmd.op   = CMD_NOP;
        o_cmd.code = ST_OK;
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = CMD_CLR;
                if (i_stat.sweep_last) begin
                    n_state = r_reply ? S_SEND : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = CMD_LOAD;
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.op = CMD_LOOK;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_SEND;
                unique case (i_stat.op)
                    OP_UPDATE: begin
                        if (i_stat.id_ok) begin
                            if (i_stat.mark == MARK_DONE) begin
                                o_cmd.op = CMD_CODE; o_cmd.code = ST_DONE;
                            end else if (i_stat.mark == MARK_QUEUED) begin
                                o_cmd.op = CMD_UPD_SET; n_state = S_UP_RD;
                            end else if (i_stat.count_full) begin
                                o_cmd.op = CMD_CODE; o_cmd.code = ST_FULL;
                            end else begin
                                o_cmd.op = CMD_INS; n_state = S_UP_RD;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.count_zero) begin
                            o_cmd.op = CMD_CODE; o_cmd.code = ST_EMPTY;
                        end else begin
                            n_state = S_TOP_RD;
                        end
                    end
                    OP_DELETE: begin
                        if (i_stat.id_ok) begin
                            if (i_stat.mark == MARK_DONE) begin
                                o_cmd.op = CMD_CODE; o_cmd.code = ST_DONE;
                            end else if (i_stat.count_zero) begin
                                o_cmd.op = CMD_CODE; o_cmd.code = ST_EMPTY;
                            end else if (i_stat.mark == MARK_QUEUED) begin
                                o_cmd.op = CMD_DEL_SET; n_state = S_UP_RD;
                            end
                        end
                    end
                    OP_CLEAR: begin
                        n_reply = 1'b1;
                        n_state = S_CLR;
                    end
                    default: n_state = S_SEND;
                endcase
            end
            S_UP_RD: begin
                if (i_stat.slot_root) begin
                    n_state = S_UP_END;
                end else begin
                    o_cmd.op = CMD_UP_RD; n_state = S_UP_PAR;
                end
            end
            S_UP_PAR: begin
                o_cmd.op = CMD_UP_PAR; n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (i_stat.op != OP_DELETE && !i_stat.up_beats) begin
                    n_state = S_UP_END;
                end else begin
                    o_cmd.op = CMD_UP_MOVE; n_state = S_UP_RD;
                end
            end
            S_UP_END: begin
                o_cmd.op = CMD_PLACE;
                n_state  = (i_stat.op == OP_DELETE) ? S_TOP_RD : S_SEND;
            end
            S_TOP_RD: begin
                o_cmd.op = CMD_TOP_RD; n_state = S_TOP_GOT;
            end
            S_TOP_GOT: begin
                o_cmd.op = CMD_TOP_GOT; n_state = S_TOP_LAST;
            end
            S_TOP_LAST: begin
                if (i_stat.count_one) begin
                    o_cmd.op = CMD_EMPTY; n_state = S_FIN;
                end else begin
                    o_cmd.op = CMD_TOP_LAST; n_state = S_DN_KEY;
                end
            end
            S_DN_KEY: begin
                o_cmd.op = CMD_DN_KEY; n_state = S_DN_L;
            end
            S_DN_L: begin
                if (i_stat.left_out) begin
                    n_state = S_DN_END;
                end else begin
                    o_cmd.op = CMD_DN_L; n_state = S_DN_LID;
                end
            end
            S_DN_LID: begin
                o_cmd.op = CMD_DN_LID; n_state = S_DN_LK;
            end
            S_DN_LK: begin
                o_cmd.op = CMD_DN_LK;
                n_state  = i_stat.right_in ? S_DN_RID : S_DN_CMP;
            end
            S_DN_RID: begin
                o_cmd.op = CMD_DN_RID; n_state = S_DN_RK;
            end
            S_DN_RK: begin
                o_cmd.op = CMD_DN_RK; n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.dn_go) begin
                    o_cmd.op = CMD_DN_MOVE; n_state = S_DN_L;
                end else begin
                    n_state = S_DN_END;
                end
            end
            S_DN_END: begin
                o_cmd.op = CMD_PLACE; n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.op == OP_REMOVE) begin
                    o_cmd.op = CMD_FIN_DONE; n_state = S_FIN_KEY;
                end else begin
                    o_cmd.op = CMD_FIN_DEL; n_state = S_SEND;
                end
            end
            S_FIN_KEY: begin
                o_cmd.op = CMD_FIN_KEY; n_state = S_SEND;
            end
            S_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.op = CMD_SEND; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= (n_state == S_CLR) ? n_reply : 1'b0;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/ibhq_dp.sv =====
// ibhq_dp: heap, position map, key and mark memories, count, config and result register
// depends on ibhq_pkg; executes commands from ibhq_ctrl
`timescale 1ns / 1ps
module ibhq_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ibhq_pkg::t_dp_cmd               i_cmd,
    output ibhq_pkg::t_dp_stat              o_stat,
    input  ibhq_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ibhq_pkg::t_out_word             o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ibhq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ibhq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ibhq_pkg::*;

    logic [ID_W-1:0]   m_hs   [0:HS_DEPTH-1];
    logic [SLOT_W-1:0] m_sof  [0:MAX_ELEMENTS-1];
    logic [KEY_W-1:0]  m_key  [0:MAX_ELEMENTS-1];
    logic [1:0]        m_mark [0:MAX_ELEMENTS-1];

    logic [ID_W-1:0]         r_hs_q;
    logic [SLOT_W-1:0]       r_sof_q;
    logic signed [KEY_W-1:0] r_key_q;
    logic [1:0]              r_mark_q;

    logic                    r_order;
    logic [CFG_DATA_W-1:0]   r_cap_cfg;
    t_op                     r_op;
    logic [ID_W-1:0]         r_id, r_elem, r_par, r_top, r_lid, r_rid, r_jid, r_sweep;
    logic signed [KEY_W-1:0] r_key_in, r_c, r_jkey;
    logic [SLOT_W-1:0]       r_slot, r_j;
    logic [CNT_W-1:0]        r_count;
    t_status                 r_status;
    logic [ID_W-1:0]         r_out_el;
    logic signed [KEY_W-1:0] r_out_key;
    logic                    r_out_valid;
    t_out_word               r_out_word;

    logic [CNT_W-1:0]  cap;
    logic [SLOT_W:0]   left, right;
    logic              full;

    logic hs_re, hs_we, sof_re, sof_we, key_re, key_we, mark_re, mark_we;
    logic [SLOT_W-1:0] hs_ra, hs_wa, sof_wd;
    logic [ID_W-1:0]   hs_wd, sof_ra, sof_wa, key_ra, key_wa, mark_ra, mark_wa;
    logic [KEY_W-1:0]  key_wd;
    logic [1:0]        mark_wd;

    always_comb begin
        if (r_cap_cfg == '0) begin
            cap = CNT_W'(1);
        end else if (r_cap_cfg > CFG_DATA_W'(MAX_ELEMENTS)) begin
            cap = CNT_W'(MAX_ELEMENTS);
        end else begin
            cap = r_cap_cfg;
        end
    end

    assign left  = {r_slot, 1'b0};
    assign right = left + (SLOT_W+1)'(1);
    assign full  = (r_count >= cap);

    assign o_stat.op         = r_op;
    assign o_stat.mark       = r_mark_q;
    assign o_stat.id_ok      = ({1'b0, r_id} < cap);
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_one  = (r_count == CNT_W'(1));
    assign o_stat.count_full = full;
    assign o_stat.slot_root  = (r_slot <= SLOT_W'(1));
    assign o_stat.left_out   = (left > {1'b0, r_count});
    assign o_stat.right_in   = (right <= {1'b0, r_count});
    assign o_stat.up_beats   = beats(r_order, r_c, r_key_q);
    assign o_stat.dn_go      = beats(r_order, r_jkey, r_c);
    assign o_stat.sweep_last = (&r_sweep);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        hs_re = 1'b0; hs_ra = '0; hs_we = 1'b0; hs_wa = '0; hs_wd = '0;
        sof_re = 1'b0; sof_ra = '0; sof_we = 1'b0; sof_wa = '0; sof_wd = '0;
        key_re = 1'b0; key_ra = '0; key_we = 1'b0; key_wa = '0; key_wd = '0;
        mark_re = 1'b0; mark_ra = '0; mark_we = 1'b0; mark_wa = '0; mark_wd = MARK_ABSENT;
        unique case (i_cmd.op)
            CMD_LOOK: begin
                mark_re = 1'b1; mark_ra = r_id;
                sof_re = 1'b1; sof_ra = r_id;
            end
            CMD_UPD_SET: begin
                key_we = 1'b1; key_wa = r_id; key_wd = r_key_in;
            end
            CMD_INS: begin
                key_we = 1'b1; key_wa = r_id; key_wd = r_key_in;
                mark_we = 1'b1; mark_wa = r_id; mark_wd = MARK_QUEUED;
            end
            CMD_UP_RD: begin
                hs_re = 1'b1; hs_ra = r_slot >> 1;
            end
            CMD_UP_PAR: begin
                key_re = 1'b1; key_ra = r_hs_q;
            end
            CMD_UP_MOVE: begin
                hs_we = 1'b1; hs_wa = r_slot; hs_wd = r_par;
                sof_we = 1'b1; sof_wa = r_par; sof_wd = r_slot;
            end
            CMD_PLACE: begin
                hs_we = 1'b1; hs_wa = r_slot; hs_wd = r_elem;
                sof_we = 1'b1; sof_wa = r_elem; sof_wd = r_slot;
            end
            CMD_TOP_RD: begin
                hs_re = 1'b1; hs_ra = SLOT_W'(1);
            end
            CMD_TOP_GOT: begin
                hs_re = 1'b1; hs_ra = r_count;
            end
            CMD_TOP_LAST: begin
                hs_we = 1'b1; hs_wa = SLOT_W'(1); hs_wd = r_hs_q;
                sof_we = 1'b1; sof_wa = r_hs_q; sof_wd = SLOT_W'(1);
                key_re = 1'b1; key_ra = r_hs_q;
            end
            CMD_DN_L: begin
                hs_re = 1'b1; hs_ra = left[SLOT_W-1:0];
            end
            CMD_DN_LID, CMD_DN_RID: begin
                key_re = 1'b1; key_ra = r_hs_q;
            end
            CMD_DN_LK: begin
                hs_re = o_stat.right_in; hs_ra = right[SLOT_W-1:0];
            end
            CMD_DN_MOVE: begin
                hs_we = 1'b1; hs_wa = r_slot; hs_wd = r_jid;
                sof_we = 1'b1; sof_wa = r_jid; sof_wd = r_slot;
            end
            CMD_FIN_DONE: begin
                mark_we = 1'b1; mark_wa = r_top; mark_wd = MARK_DONE;
                key_re = 1'b1; key_ra = r_top;
            end
            CMD_FIN_DEL: begin
                mark_we = 1'b1; mark_wa = r_id; mark_wd = MARK_ABSENT;
            end
            CMD_CLR: begin
                mark_we = 1'b1; mark_wa = r_sweep; mark_wd = MARK_ABSENT;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hs_we) m_hs[hs_wa] <= hs_wd;
        if (hs_re) r_hs_q <= m_hs[hs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sof_we) m_sof[sof_wa] <= sof_wd;
        if (sof_re) r_sof_q <= m_sof[sof_ra];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) m_key[key_wa] <= key_wd;
        if (key_re) r_key_q <= m_key[key_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) m_mark[mark_wa] <= mark_wd;
        if (mark_re) r_mark_q <= m_mark[mark_ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order     <= 1'b0;
            r_cap_cfg   <= CFG_DATA_W'(MAX_ELEMENTS);
            r_count     <= '0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_ORDER) begin
                    r_order <= i_cfg_data[0];
                end else if (i_cfg_index == REG_CAP) begin
                    r_cap_cfg <= i_cfg_data;
                end
            end
            unique case (i_cmd.op)
                CMD_INS:      r_count <= r_count + CNT_W'(1);
                CMD_EMPTY:    r_count <= '0;
                CMD_TOP_LAST: r_count <= r_count - CNT_W'(1);
                CMD_CLR: begin
                    r_count <= '0;
                    r_sweep <= r_sweep + ID_W'(1);
                end
                default: begin
                end
            endcase
            if (i_cmd.op == CMD_SEND) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CMD_LOAD: begin
                r_op      <= t_op'(i_in_word.opcode);
                r_id      <= i_in_word.element_id;
                r_key_in  <= i_in_word.key_value;
                r_status  <= ST_OK;
                r_out_el  <= '0;
                r_out_key <= '0;
            end
            CMD_CODE: r_status <= i_cmd.code;
            CMD_UPD_SET: begin
                r_slot <= r_sof_q; r_elem <= r_id; r_c <= r_key_in;
            end
            CMD_INS: begin
                r_slot <= r_count + CNT_W'(1); r_elem <= r_id; r_c <= r_key_in;
            end
            CMD_DEL_SET: begin
                r_slot <= r_sof_q; r_elem <= r_id;
            end
            CMD_UP_PAR:  r_par <= r_hs_q;
            CMD_UP_MOVE: r_slot <= r_slot >> 1;
            CMD_TOP_GOT: r_top <= r_hs_q;
            CMD_TOP_LAST: begin
                r_elem <= r_hs_q; r_slot <= SLOT_W'(1);
            end
            CMD_DN_KEY: r_c <= r_key_q;
            CMD_DN_LID: r_lid <= r_hs_q;
            CMD_DN_LK: begin
                r_jkey <= r_key_q; r_j <= left[SLOT_W-1:0]; r_jid <= r_lid;
            end
            CMD_DN_RID: r_rid <= r_hs_q;
            CMD_DN_RK: begin
                if (beats(r_order, r_key_q, r_jkey)) begin
                    r_jkey <= r_key_q; r_j <= right[SLOT_W-1:0]; r_jid <= r_rid;
                end
            end
            CMD_DN_MOVE: r_slot <= r_j;
            CMD_FIN_KEY: begin
                r_out_el <= r_top; r_out_key <= r_key_q;
            end
            CMD_SEND: begin
                r_out_word.status       <= r_status;
                r_out_word.out_element  <= r_out_el;
                r_out_word.out_key      <= r_out_key;
                r_out_word.queued_count <= r_count;
                r_out_word.is_empty     <= (r_count == '0);
                r_out_word.is_full      <= full;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/indexed_binary_heap_queue_core.sv =====
// channel  dir  handshake                 payload
// in       in   i_in_valid / o_in_stall   i_in_word  (t_in_word)
// out      out  o_out_valid / i_out_stall o_out_word (t_out_word)
// cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one word at a time; a refused word or no-op only sets a status before the result is offered,
// an update climbs the heap level by level until it no longer beats its parent or is at the root,
// a remove takes the root and sifts the last entry down level by level until no child beats it,
// a delete climbs its entry to the root and then takes it off the root; clear sweeps all marks
// after reset a pass over all 4096 entries clears the marks; input stalls meanwhile
// a finished word waits in the output register while the next word is taken
// top level of the heap queue; depends on ibhq_pkg, ibhq_ctrl, ibhq_dp
`timescale 1ns / 1ps
module indexed_binary_heap_queue_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ibhq_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ibhq_pkg::t_out_word             o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ibhq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ibhq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ibhq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ibhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ibhq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ===== rtl/ibhq_checker.sv =====
// ibhq_checker: port-level checks on the heap queue, bound to the top level
// depends on ibhq_pkg and indexed_binary_heap_queue_core
`timescale 1ns / 1ps
module ibhq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ibhq_pkg::t_out_word o_out_word
);
    import ibhq_pkg::*;

    // held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // a taken word keeps the input stalled the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous word in work");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.is_empty == (o_out_word.queued_count == '0)))
        else $error("empty flag disagrees with count");

    a_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.out_element != '0) |-> (o_out_word.status == ST_OK))
        else $error("removed element with failing status");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.queued_count <= CNT_W'(MAX_ELEMENTS)))
        else $error("count beyond capacity");

endmodule

bind indexed_binary_heap_queue_core ibhq_checker u_ibhq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
